// ===== design/ecrt_pkg.sv =====
`default_nettype none

package ecrt_pkg;

    // Q1.30 probability format
    localparam int QB = 30;
    localparam int QSTEPS = QB + 1;
    localparam int XW = QB + 1;
    localparam logic [XW-1:0] Q30_ONE = XW'(1) << QB;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_CHECK,
        S_DIVB,
        S_MULB,
        S_MULX,
        S_DIVM,
        S_DIVC,
        S_MULW,
        S_DIVW,
        S_DONE
    } ecrt_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PROD,
        OP_OVER,
        OP_DIV_B1,
        OP_MUL_B,
        OP_DIV_B,
        OP_MUL_X,
        OP_DIV_M,
        OP_DIV_C,
        OP_MUL_W,
        OP_DIV_W,
        OP_RES,
        OP_OUT
    } ecrt_op_t;

    typedef struct packed {
        ecrt_op_t op;
        logic     in_ready;
    } ecrt_cmd_t;

    typedef struct packed {
        logic overload;
        logic k_last;
        logic mul_done;
        logic div_done;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } ecrt_status_t;

endpackage

`default_nettype wire

// ===== design/erlang_c_residence_time.sv =====
// Mean residence time of an M/M/m queue. Each input word (arrival rate and service
// time in unsigned fixed point with FRAC_BITS fraction bits, server count m) yields
// one output word: service time plus Erlang C mean wait, saturating at all ones, with
// tuser set when the offered load reaches m (result then all ones). Counts above
// MAX_SERVERS are taken as MAX_SERVERS. One word is in flight at a time; its run is
// set by the Erlang B recursion, where each server step runs a shift-add multiply
// followed by a restoring divide on the shared serial units; the final wait and load
// divisions follow on the same units. An overloaded word skips the recursion and the
// divisions. The finished word sits in an output register while the next input word
// is accepted.
`default_nettype none

module erlang_c_residence_time
    import ecrt_pkg::*;
#(
    parameter int MAX_SERVERS = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] arrival_rate, [63:32] service_time, [70:64] server_count, [71] zero
    input  wire logic [71:0]    s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [31:0] residence_time
    output logic [31:0]         m_axis_tdata,
    // [0] saturated
    output logic [0:0]          m_axis_tuser
);

    ecrt_cmd_t    cmd;
    ecrt_status_t status;

    ecrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    ecrt_datapath #(
        .MAX_SERVERS (MAX_SERVERS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .arrival_rate   (s_axis_tdata[31:0]),
        .service_time   (s_axis_tdata[63:32]),
        .server_count   (s_axis_tdata[70:64]),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .residence_time (m_axis_tdata),
        .saturated      (m_axis_tuser[0])
    );

    assign s_axis_tready = cmd.in_ready;

    // overloaded result is always all ones
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == MAX32)
        else $error("saturated result not at maximum");

    // no new word while a serial unit is still running
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !status.mul_busy && !status.div_busy)
        else $error("input ready while arithmetic busy");

    // multiplier and divider never finish together
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.mul_done && status.div_done))
        else $error("multiply and divide finished together");

endmodule

`default_nettype wire

// ===== design/ecrt_mul.sv =====
`default_nettype none

// Shift-add multiplier, one bit of x per cycle, msb first
module ecrt_mul
    import ecrt_pkg::*;
#(
    parameter int YW = 36
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [XW-1:0]      x,
    input  wire logic [YW-1:0]      y,
    output logic                    busy,
    output logic                    done,
    output logic [XW+YW-1:0]        prod
);

    localparam int PW = XW + YW;
    localparam int CW = $clog2(XW + 1);

    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // next values
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x;
            y_next    = y;
            acc_next  = '0;
            cnt_next  = CW'(XW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[PW-2:0], 1'b0} + (x_reg[XW-1] ? PW'(y_reg) : '0);
            x_next   = {x_reg[XW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== design/ecrt_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// q30 mode: floor(num*2^30/d) for num <= d, 31 steps. Plain mode: num/d, NW steps.
module ecrt_div
    import ecrt_pkg::*;
#(
    parameter int NW  = 63,
    parameter int DVW = 37
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               q30,
    input  wire logic [NW-1:0]      num,
    input  wire logic [DVW-1:0]     d,
    output logic                    busy,
    output logic                    done,
    output logic [NW-1:0]           quot
);

    localparam int CW = $clog2(NW + 1);

    logic [DVW-1:0] r_reg, r_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [DVW-1:0] d_reg, d_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DVW:0]   rs;
    logic           ge;

    // trial subtract
    assign rs = {r_reg, n_reg[NW-1]};
    assign ge = rs >= {1'b0, d_reg};

    always_comb
    begin
        r_next    = r_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            d_next    = d;
            busy_next = 1'b1;
            if (q30)
            begin
                r_next   = DVW'(num >> 1);
                n_next   = {num[0], {(NW-1){1'b0}}};
                cnt_next = CW'(QSTEPS);
            end
            else
            begin
                r_next   = '0;
                n_next   = num;
                cnt_next = CW'(NW);
            end
        end
        else if (busy_reg)
        begin
            r_next   = ge ? DVW'(rs - {1'b0, d_reg}) : DVW'(rs);
            n_next   = {n_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        n_reg <= n_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = n_reg;

endmodule

`default_nettype wire

// ===== design/ecrt_datapath.sv =====
`default_nettype none

module ecrt_datapath
    import ecrt_pkg::*;
#(
    parameter int MAX_SERVERS = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ecrt_cmd_t      cmd,
    output ecrt_status_t        status,
    input  wire logic [31:0]    arrival_rate,
    input  wire logic [31:0]    service_time,
    input  wire logic [6:0]     server_count,
    output logic                res_valid,
    input  wire logic           res_ready,
    output logic [31:0]         residence_time,
    output logic                saturated
);

    localparam int MW  = $clog2(MAX_SERVERS + 1);
    localparam int AW  = MW + QB;
    localparam int DVW = AW + 1;
    localparam int NW  = (AW > 63) ? AW : 63;
    localparam int YW  = (AW > 32) ? AW : 32;
    localparam int PW  = XW + YW;
    localparam int ESH = 2 * FRAC_BITS - QB;
    localparam int ESR = (ESH > 0) ? ESH : 0;
    localparam int ESL = (ESH < 0) ? -ESH : 0;

    logic [31:0]    lam_reg, svc_reg;
    logic [MW-1:0]  m_reg, k_reg;
    logic [63:0]    prod_reg;
    logic [AW-1:0]  a_reg;
    logic [XW-1:0]  b_reg;
    logic [31:0]    res_reg, out_res_reg;
    logic           sat_reg, out_sat_reg;
    logic           out_valid_reg, out_valid_next;

    logic [63:0]    prod;
    logic [MW-1:0]  m_in;
    logic           mul_start, mul_busy, mul_done;
    logic [XW-1:0]  mul_x;
    logic [YW-1:0]  mul_y;
    logic [PW-1:0]  mul_prod;
    logic           div_start, div_q30, div_busy, div_done;
    logic [NW-1:0]  div_num, div_quot;
    logic [DVW-1:0] div_d;
    logic [AW-1:0]  mul_hi;
    logic [XW-1:0]  b_new, c_clamp;
    logic [32:0]    sum;

    assign prod    = 64'(lam_reg) * 64'(svc_reg);
    assign m_in    = (32'(server_count) > MAX_SERVERS) ? MW'(MAX_SERVERS) : MW'(server_count);
    assign mul_hi  = AW'(mul_prod >> QB);
    assign b_new   = XW'(div_quot);
    assign c_clamp = (div_quot > NW'(Q30_ONE)) ? Q30_ONE : XW'(div_quot);
    assign sum     = {1'b0, svc_reg} + {1'b0, div_quot[31:0]};

    // unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        mul_x     = b_new;
        mul_y     = YW'(a_reg);
        div_start = 1'b0;
        div_q30   = 1'b1;
        div_num   = NW'(a_reg);
        div_d     = DVW'(Q30_ONE) + DVW'(a_reg);
        unique case (cmd.op)
            OP_DIV_B1:
            begin
                div_start = 1'b1;
            end
            OP_MUL_B:
            begin
                mul_start = 1'b1;
            end
            OP_DIV_B:
            begin
                div_start = 1'b1;
                div_num   = NW'(mul_hi);
                div_d     = (DVW'(k_reg) << QB) + DVW'(mul_hi);
            end
            OP_MUL_X:
            begin
                mul_start = 1'b1;
                mul_x     = Q30_ONE - b_new;
            end
            OP_DIV_M:
            begin
                div_start = 1'b1;
                div_q30   = 1'b0;
                div_num   = NW'(mul_hi);
                div_d     = DVW'(m_reg);
            end
            OP_DIV_C:
            begin
                div_start = 1'b1;
                div_num   = NW'(b_reg);
                div_d     = DVW'(Q30_ONE) - DVW'(div_quot);
            end
            OP_MUL_W:
            begin
                mul_start = 1'b1;
                mul_x     = c_clamp;
                mul_y     = YW'(svc_reg);
            end
            OP_DIV_W:
            begin
                div_start = 1'b1;
                div_q30   = 1'b0;
                div_num   = NW'(mul_prod);
                div_d     = (DVW'(m_reg) << QB) - DVW'(a_reg);
            end
            default:
            begin
            end
        endcase
    end

    ecrt_mul #(.YW(YW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ecrt_div #(.NW(NW), .DVW(DVW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .q30   (div_q30),
        .num   (div_num),
        .d     (div_d),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                lam_reg <= arrival_rate;
                svc_reg <= service_time;
                m_reg   <= m_in;
            end
            OP_PROD:
            begin
                prod_reg <= prod;
                a_reg    <= AW'((prod >> ESR) << ESL);
            end
            OP_OVER:
            begin
                res_reg <= MAX32;
                sat_reg <= 1'b1;
            end
            OP_DIV_B1:
            begin
                k_reg <= MW'(1);
            end
            OP_MUL_B:
            begin
                b_reg <= b_new;
                k_reg <= k_reg + 1'b1;
            end
            OP_MUL_X:
            begin
                b_reg <= b_new;
            end
            OP_RES:
            begin
                sat_reg <= 1'b0;
                if (div_quot > NW'(MAX32) || sum[32])
                    res_reg <= MAX32;
                else
                    res_reg <= sum[31:0];
            end
            OP_OUT:
            begin
                out_res_reg <= res_reg;
                out_sat_reg <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.overload = (prod_reg >> (2 * FRAC_BITS)) >= 64'(m_reg);
    assign status.k_last   = k_reg == m_reg;
    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.mul_busy = mul_busy;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || res_ready;

    assign res_valid      = out_valid_reg;
    assign residence_time = out_res_reg;
    assign saturated      = out_sat_reg;

endmodule

`default_nettype wire

// ===== design/ecrt_ctrl.sv =====
`default_nettype none

module ecrt_ctrl
    import ecrt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire ecrt_status_t   status,
    output ecrt_cmd_t           cmd
);

    ecrt_state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PROD;
            S_PROD:  state_next = S_CHECK;
            S_CHECK: state_next = status.overload ? S_DONE : S_DIVB;
            S_DIVB:  if (status.div_done) state_next = status.k_last ? S_MULX : S_MULB;
            S_MULB:  if (status.mul_done) state_next = S_DIVB;
            S_MULX:  if (status.mul_done) state_next = S_DIVM;
            S_DIVM:  if (status.div_done) state_next = S_DIVC;
            S_DIVC:  if (status.div_done) state_next = S_MULW;
            S_MULW:  if (status.mul_done) state_next = S_DIVW;
            S_DIVW:  if (status.div_done) state_next = S_DONE;
            S_DONE:  if (status.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            S_PROD:  cmd.op = OP_PROD;
            S_CHECK: cmd.op = status.overload ? OP_OVER : OP_DIV_B1;
            S_DIVB:  if (status.div_done) cmd.op = status.k_last ? OP_MUL_X : OP_MUL_B;
            S_MULB:  if (status.mul_done) cmd.op = OP_DIV_B;
            S_MULX:  if (status.mul_done) cmd.op = OP_DIV_M;
            S_DIVM:  if (status.div_done) cmd.op = OP_DIV_C;
            S_DIVC:  if (status.div_done) cmd.op = OP_MUL_W;
            S_MULW:  if (status.mul_done) cmd.op = OP_DIV_W;
            S_DIVW:  if (status.div_done) cmd.op = OP_RES;
            S_DONE:  if (status.out_free) cmd.op = OP_OUT;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
